// File: hdl/stm_pkg.sv
package stm_pkg;

	// Table geometry
	localparam int CAPACITY   = 256;
	localparam int COORD_BITS = 16;
	localparam int SLOT_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int CODE_BITS  = 8;
	localparam int SPAN_BITS  = COORD_BITS + 1;

	// Stream payload widths
	localparam int IN_RAW_BITS   = 2 * COORD_BITS + CODE_BITS;
	localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_BITS  = CODE_BITS + 2 * SPAN_BITS + 4 * COORD_BITS + 2;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	// Codes
	localparam logic                 ACT_WRITE  = 1'b0;
	localparam logic                 ACT_READ   = 1'b1;
	localparam logic [CODE_BITS-1:0] ERASE_CODE = 8'hFF;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One table entry as held in the slot memory
	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		coord_t               y;
		coord_t               x;
	} slot_t;

	// Bounding box
	typedef struct packed {
		coord_t hi_y;
		coord_t lo_y;
		coord_t hi_x;
		coord_t lo_x;
	} box_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_WALK,
		ST_RESP
	} state_t;

endpackage

// File: hdl/sparse_tile_map_with_bounds_unit.sv
// Channel  Dir  Beat fields
// s_axis   in   tuser: action; tdata: tile_x, tile_y, tile_code
// m_axis   out  tdata: read_code, map_width, map_height, bound_min_x, bound_max_x,
//                      bound_min_y, bound_max_y, map_empty, insert_dropped
//
// One beat at a time. A lookup scan reads every slot of the table through the
// single read port of the slot memory; ST_APPLY then updates the table, ST_RESP
// holds the result on m_axis until it is taken, and the block returns to ST_IDLE
// before the next beat is taken.
// An erase on an edge of the box adds a second sweep that rebuilds the box.
// Reset clears the valid bits, the fill count and the box at once; no clearing pass.
// s_tready is low from acceptance until the result beat is taken; a stalled m_tready
// holds the result and the block.
module sparse_tile_map_with_bounds_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [stm_pkg::IN_DATA_BITS-1:0]  s_tdata,  // tile_x, tile_y, tile_code
	input  logic                              s_tuser,  // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_code, map_width, map_height, bound_min_x, bound_max_x, bound_min_y,
	// bound_max_y, map_empty, insert_dropped, zero fill
	output logic [stm_pkg::OUT_DATA_BITS-1:0] m_tdata
);
	import stm_pkg::*;

	state_t state_q, state_nxt;

	logic                 act_q;
	coord_t               x_q, y_q;
	logic [CODE_BITS-1:0] tcode_q;

	logic [CAPACITY-1:0]  valid_q;
	logic [CNT_BITS-1:0]  fill_q;
	logic [CNT_BITS-1:0]  cnt_q;
	box_t                 box_q;
	logic                 empty_q;
	logic                 first_q;

	logic                 rd_act_s1, rd_vld_s1;
	logic [SLOT_BITS-1:0] rd_idx_s1;

	logic                 hit_q, free_ok_q;
	logic [SLOT_BITS-1:0] hit_idx_q, free_idx_q;
	logic [CODE_BITS-1:0] hit_code_q;
	logic [CODE_BITS-1:0] read_code_q;
	logic                 dropped_q;

	logic                 issue;
	logic                 sweep_done;
	logic                 go_walk;
	logic                 do_store;
	logic [SLOT_BITS-1:0] store_idx;
	slot_t                ram_rdata, ram_wdata;

	coord_t               bu_px, bu_py;
	logic                 bu_first;
	box_t                 bu_box_next;
	logic                 bu_edge;

	logic [SPAN_BITS-1:0] map_width, map_height;
	logic [OUT_RAW_BITS-1:0] out_raw;

	// Slot memory holds x, y and code of every slot
	stm_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (do_store),
		.waddr(store_idx),
		.wdata(ram_wdata),
		.raddr(cnt_q[SLOT_BITS-1:0]),
		.rdata(ram_rdata)
	);

	assign ram_wdata = '{code: tcode_q, y: y_q, x: x_q};

	// Shared box unit: fed by the stored slot in a sweep, by the beat otherwise
	always_comb begin
		if (state_q == ST_WALK) begin
			bu_px    = ram_rdata.x;
			bu_py    = ram_rdata.y;
			bu_first = first_q;
		end else begin
			bu_px    = x_q;
			bu_py    = y_q;
			bu_first = empty_q;
		end
	end

	stm_box u_box (
		.px      (bu_px),
		.py      (bu_py),
		.first   (bu_first),
		.box     (box_q),
		.box_next(bu_box_next),
		.on_edge (bu_edge)
	);

	assign sweep_done = (cnt_q == CNT_BITS'(CAPACITY));
	assign store_idx  = hit_q ? hit_idx_q : free_idx_q;
	assign do_store   = (state_q == ST_APPLY) && (act_q == ACT_WRITE) &&
		(tcode_q != ERASE_CODE) && (hit_q || free_ok_q);
	assign go_walk    = (act_q == ACT_WRITE) && (tcode_q == ERASE_CODE) && hit_q &&
		(fill_q != CNT_BITS'(1)) && bu_edge;

	// Sequencer: next state and handshake
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = !sweep_done;
				if (sweep_done) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_nxt = go_walk ? ST_WALK : ST_RESP;
			end
			ST_WALK: begin
				issue = !sweep_done;
				if (sweep_done) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q   <= s_tuser;
			x_q     <= coord_t'(s_tdata[COORD_BITS-1:0]);
			y_q     <= coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
			tcode_q <= s_tdata[IN_RAW_BITS-1:2*COORD_BITS];
		end
	end

	// Read stage: slot index and valid bit travel beside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_s1 <= 1'b0;
		end else begin
			rd_act_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[cnt_q[SLOT_BITS-1:0]];
		rd_idx_s1 <= cnt_q[SLOT_BITS-1:0];
	end

	// Sweep counter: restart on a new beat and before a box sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((s_tvalid && s_tready) || (state_q == ST_APPLY)) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	// Lookup: find the matching slot and the lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && rd_act_s1) begin
			if (rd_vld_s1 && (ram_rdata.x == x_q) && (ram_rdata.y == y_q)) begin
				hit_q <= 1'b1;
			end
			if (!rd_vld_s1 && !free_ok_q) begin
				free_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && rd_act_s1) begin
			if (rd_vld_s1 && (ram_rdata.x == x_q) && (ram_rdata.y == y_q)) begin
				hit_idx_q  <= rd_idx_s1;
				hit_code_q <= ram_rdata.code;
			end
			if (!rd_vld_s1 && !free_ok_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// Update valid bits, fill count and box; sweep the box after an edge erase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			box_q   <= '0;
			empty_q <= 1'b1;
			first_q <= 1'b0;
		end else if (state_q == ST_APPLY) begin
			if ((act_q == ACT_WRITE) && (tcode_q == ERASE_CODE)) begin
				if (hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
					fill_q             <= fill_q - CNT_BITS'(1);
					if (fill_q == CNT_BITS'(1)) begin
						box_q   <= '0;
						empty_q <= 1'b1;
					end
					first_q <= 1'b1;
				end
			end else if (do_store) begin
				valid_q[store_idx] <= 1'b1;
				if (!hit_q) begin
					fill_q <= fill_q + CNT_BITS'(1);
				end
				box_q   <= bu_box_next;
				empty_q <= 1'b0;
			end
		end else if ((state_q == ST_WALK) && rd_act_s1 && rd_vld_s1) begin
			box_q   <= bu_box_next;
			first_q <= 1'b0;
		end
	end

	// Hold the result fields for the response beat
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			dropped_q <= 1'b0;
			if (act_q == ACT_READ) begin
				read_code_q <= hit_q ? hit_code_q : ERASE_CODE;
			end else begin
				read_code_q <= '0;
				if ((tcode_q != ERASE_CODE) && !hit_q && !free_ok_q) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	// Spans of the box, zero when empty
	assign map_width = empty_q ? '0 :
		SPAN_BITS'({box_q.hi_x[COORD_BITS-1], box_q.hi_x} -
		{box_q.lo_x[COORD_BITS-1], box_q.lo_x} + SPAN_BITS'(1));
	assign map_height = empty_q ? '0 :
		SPAN_BITS'({box_q.hi_y[COORD_BITS-1], box_q.hi_y} -
		{box_q.lo_y[COORD_BITS-1], box_q.lo_y} + SPAN_BITS'(1));

	assign out_raw = {dropped_q, empty_q, box_q.hi_y, box_q.lo_y, box_q.hi_x, box_q.lo_x,
		map_height, map_width, read_code_q};
	assign m_tdata = OUT_DATA_BITS'(out_raw);

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(CAPACITY))
		else $error("fill count beyond capacity");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (fill_q == '0))
		else $error("empty flag disagrees with fill count");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (box_q == '0))
		else $error("empty map with nonzero box");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("new beat taken while a result is pending");

endmodule

// File: hdl/stm_ram.sv
module stm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/stm_box.sv
module stm_box (
	input  stm_pkg::coord_t px,
	input  stm_pkg::coord_t py,
	input  logic            first,
	input  stm_pkg::box_t   box,
	output stm_pkg::box_t   box_next,
	output logic            on_edge
);
	import stm_pkg::*;

	// Widen the box by one point; a first point seeds it
	always_comb begin
		box_next.lo_x = (first || (px < box.lo_x)) ? px : box.lo_x;
		box_next.hi_x = (first || (px > box.hi_x)) ? px : box.hi_x;
		box_next.lo_y = (first || (py < box.lo_y)) ? py : box.lo_y;
		box_next.hi_y = (first || (py > box.hi_y)) ? py : box.hi_y;
	end

	// Flag a point that lies on any edge of the box
	assign on_edge = (px == box.lo_x) || (px == box.hi_x) ||
		(py == box.lo_y) || (py == box.hi_y);

endmodule
